/* src/assert_macros.svh */
// Assertion macros shared by the shortest path RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is low
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must never hold, checked at every rising clock edge
`define AST_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* src/ssp_pkg.sv */
// Types and constants of the shortest path engine
package ssp_pkg;

    localparam int DIST_BITS = 21;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CHK,
        ST_LD_WR2,
        ST_SCAN,
        ST_EMIT,
        ST_DRAIN
    } t_state;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [DIST_BITS-1:0] best;
    } t_tok;

    // Relaxation beat for one matrix column
    typedef struct packed {
        logic                 en;
        logic                 edge_ok;
        logic [DIST_BITS-1:0] cand;
    } t_relax;

endpackage

/* src/ssp_req_if.sv */
// Request channel: edge load, run and clear beats
interface ssp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
    logic [15:0] edge_weight;

    modport source (output valid, req_type, vertex_a, vertex_b, edge_weight, input ready);
    modport sink (input valid, req_type, vertex_a, vertex_b, edge_weight, output ready);
endinterface

/* src/ssp_res_if.sv */
// Result channel: one beat per vertex of a run
interface ssp_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  vertex_index;
    logic [20:0] path_length;
    logic        reachable;
    logic        last_result;

    modport source (output valid, vertex_index, path_length, reachable, last_result,
                    input ready);
    modport sink (input valid, vertex_index, path_length, reachable, last_result,
                  output ready);
endinterface

/* src/ssp_ram.sv */
// Generic single write port RAM with registered read
module ssp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, and read the same address into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ssp_cell.sv */
// One vertex cell: distance, reached and visited flags, minimum token stage
module ssp_cell
    import ssp_pkg::*;
#(
    parameter int VW  = 5,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_init,
    input  logic                 i_is_src,
    input  logic                 i_active,
    input  t_relax               i_relax,
    input  logic [VW-1:0]        i_relax_col,
    input  logic                 i_visit,
    input  logic [VW-1:0]        i_visit_idx,
    input  t_tok                 i_tok,
    input  logic [VW-1:0]        i_tok_idx,
    output t_tok                 o_tok,
    output logic [VW-1:0]        o_tok_idx,
    output logic [DIST_BITS-1:0] o_dist,
    output logic                 o_reached
);
    logic                 r_reached, n_reached;
    logic                 r_visited, n_visited;
    logic [DIST_BITS-1:0] r_dist, n_dist;
    t_tok                 r_tok, n_tok;
    logic [VW-1:0]        r_tok_idx, n_tok_idx;
    logic                 w_take;

    // update own entry from init, relax and visit beats
    always_comb begin
        n_reached = r_reached;
        n_visited = r_visited;
        n_dist    = r_dist;
        if (i_init) begin
            n_reached = i_active && i_is_src;
            n_visited = 1'b0;
            n_dist    = '0;
        end else begin
            if (i_active && i_relax.en && i_relax.edge_ok && (i_relax_col == VW'(IDX)) &&
                (!r_reached || (i_relax.cand < r_dist))) begin
                n_reached = 1'b1;
                n_dist    = i_relax.cand;
            end
            if (i_visit && (i_visit_idx == VW'(IDX))) begin
                n_visited = 1'b1;
            end
        end
    end

    // fold own distance into the passing minimum
    always_comb begin
        w_take = i_tok.valid && i_active && r_reached && !r_visited &&
                 (!i_tok.found || (r_dist < i_tok.best));
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (w_take) begin
            n_tok.found = 1'b1;
            n_tok.best  = r_dist;
            n_tok_idx   = VW'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= 1'b0;
            r_visited <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_reached <= n_reached;
            r_visited <= n_visited;
            r_tok     <= n_tok;
        end
        r_dist    <= n_dist;
        r_tok_idx <= n_tok_idx;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;
    assign o_dist    = r_dist;
    assign o_reached = r_reached;
endmodule

/* src/single_source_shortest_path_top.sv */
// Top level of the dense-graph shortest path engine
//
//  port    dir  role
//  i_req   in   edge load / run / clear beats (valid, ready)
//  o_res   out  one beat per vertex after a run (valid, ready)
//  i_cfg_* in   register write: 0 source vertex, 1 vertex count
//
// Load: read-check-write on the matrix RAM port (states LD_RD, LD_CHK, LD_WR2).
// Clear: writes all MAX_VERTICES squared entries, one per cycle; the same sweep
// runs after reset, and no request is taken until it ends.
// Run: per selected vertex, one matrix row read per cycle and the minimum token
// walking the cell chain; then one result beat per vertex.
// A stalled result holds the engine; requests wait while any run is in flight.
`include "assert_macros.svh"
module single_source_shortest_path_top
    import ssp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data,
    ssp_req_if.sink    i_req,
    ssp_res_if.source  o_res
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;
    localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_CNT = 1'b1;

    // configuration
    logic [4:0] r_src;
    logic [5:0] r_cnt;

    // control
    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr;
    logic [VW-1:0]        r_a, r_b;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [CW-1:0]        r_n, w_n_eff;
    logic [CW-1:0]        r_k;
    logic [VW-1:0]        r_cur;
    logic [DIST_BITS-1:0] r_best;
    logic                 r_first;
    logic                 r_rd_valid;
    logic [VW-1:0]        r_rd_col;
    t_relax               r_rx, w_rx;
    logic [VW-1:0]        r_rx_col;
    logic                 r_tok_start;
    logic [VW-1:0]        r_emit_idx;
    logic                 r_out_valid;
    logic [4:0]           r_out_vidx;
    logic [DIST_BITS-1:0] r_out_path;
    logic                 r_out_reach;
    logic                 r_out_last;

    // matrix port and strobes
    logic                   w_we;
    logic [AW-1:0]          w_addr;
    logic [WEIGHT_BITS:0]   w_wdata;
    logic [WEIGHT_BITS:0]   w_rdata;
    logic                   w_accept;
    logic                   w_ends_ok;
    logic                   w_issue;
    logic                   w_init;
    logic                   w_tok_end;
    logic                   w_visit;
    logic                   w_emit_load;
    logic                   w_emit_last;
    logic [SW-1:0]          w_sum;

    // cell chain
    t_tok                 w_tok_in  [MAX_VERTICES];
    t_tok                 w_tok_out [MAX_VERTICES];
    logic [VW-1:0]        w_idx_in  [MAX_VERTICES];
    logic [VW-1:0]        w_idx_out [MAX_VERTICES];
    logic [DIST_BITS-1:0] w_dist    [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] w_reached;
    logic [MAX_VERTICES-1:0] w_active;
    logic [MAX_VERTICES-1:0] w_is_src;
    logic [MAX_VERTICES-1:0] w_tok_valid;

    assign w_accept  = i_req.valid && i_req.ready;
    assign w_ends_ok = (32'(i_req.vertex_a) < MAX_VERTICES) &&
                       (32'(i_req.vertex_b) < MAX_VERTICES);
    assign w_n_eff   = CW'((r_cnt == '0) ? 1 :
                           ((32'(r_cnt) > MAX_VERTICES) ? MAX_VERTICES : 32'(r_cnt)));
    assign w_tok_end = w_tok_out[MAX_VERTICES-1].valid;
    assign w_emit_last = ((CW'(r_emit_idx) + CW'(1)) == r_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.req_type)
                        REQ_LOAD:  n_state = w_ends_ok ? ST_LD_RD : ST_IDLE;
                        REQ_RUN:   n_state = ST_SCAN;
                        REQ_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LD_RD:  n_state = ST_LD_CHK;
            ST_LD_CHK: n_state = w_rdata[WEIGHT_BITS] ? ST_IDLE : ST_LD_WR2;
            ST_LD_WR2: n_state = ST_IDLE;
            ST_SCAN: begin
                if (w_tok_end && !w_tok_out[MAX_VERTICES-1].found) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit_load && w_emit_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (o_res.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_req.ready = 1'b0;
        w_we        = 1'b0;
        w_addr      = {r_a, r_b};
        w_wdata     = {1'b1, r_w};
        w_issue     = 1'b0;
        w_init      = 1'b0;
        w_visit     = 1'b0;
        w_emit_load = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr;
                w_wdata = '0;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                w_init      = i_req.valid && (i_req.req_type == REQ_RUN);
            end
            ST_LD_CHK: begin
                w_we = !w_rdata[WEIGHT_BITS];
            end
            ST_LD_WR2: begin
                w_we   = 1'b1;
                w_addr = {r_b, r_a};
            end
            ST_SCAN: begin
                w_issue = (32'(r_k) < MAX_VERTICES);
                w_addr  = {r_cur, r_k[VW-1:0]};
                w_visit = w_tok_end && w_tok_out[MAX_VERTICES-1].found;
            end
            ST_EMIT: begin
                w_emit_load = !r_out_valid || o_res.ready;
            end
            default: ;
        endcase
    end

    // candidate distance for the column that just came out of the RAM
    always_comb begin
        w_sum      = SW'(r_best) + SW'(w_rdata[WEIGHT_BITS-1:0]);
        w_rx.en      = r_rd_valid;
        w_rx.edge_ok = !r_first && w_rdata[WEIGHT_BITS];
        w_rx.cand    = (w_sum > SW'(DIST_MAX)) ? DIST_MAX : w_sum[DIST_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_src       <= 5'd0;
            r_cnt       <= 6'd32;
            r_k         <= '0;
            r_rd_valid  <= 1'b0;
            r_rx        <= '0;
            r_tok_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b1;
            r_emit_idx  <= '0;
        end else begin
            r_state <= n_state;
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SRC: r_src <= i_cfg_data[4:0];
                    CFG_CNT: r_cnt <= i_cfg_data;
                    default: ;
                endcase
            end
            // sweep counter for the matrix clear
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            else                     r_clr <= '0;
            // row read pointer
            if (w_init || w_tok_end)  r_k <= '0;
            else if (w_issue)         r_k <= r_k + CW'(1);
            if (w_init)       r_first <= 1'b1;
            else if (w_visit) r_first <= 1'b0;
            r_rd_valid  <= w_issue;
            r_rx        <= w_rx;
            r_tok_start <= r_rx.en && (r_rx_col == '0);
            // emit index
            if (w_init)           r_emit_idx <= '0;
            else if (w_emit_load) r_emit_idx <= r_emit_idx + VW'(1);
            // output register
            if (w_emit_load)      r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
        // payload
        if (w_accept) begin
            r_a <= VW'(i_req.vertex_a);
            r_b <= VW'(i_req.vertex_b);
            r_w <= WEIGHT_BITS'(i_req.edge_weight);
        end
        if (w_init) begin
            r_n    <= w_n_eff;
            r_cur  <= '0;
            r_best <= '0;
        end else if (w_visit) begin
            r_cur  <= w_idx_out[MAX_VERTICES-1];
            r_best <= w_tok_out[MAX_VERTICES-1].best;
        end
        r_rd_col <= r_k[VW-1:0];
        r_rx_col <= r_rd_col;
        if (w_emit_load) begin
            r_out_vidx  <= 5'(r_emit_idx);
            r_out_path  <= w_reached[r_emit_idx] ? w_dist[r_emit_idx] : '0;
            r_out_reach <= w_reached[r_emit_idx];
            r_out_last  <= w_emit_last;
        end
    end

    ssp_ram #(
        .WIDTH (WEIGHT_BITS + 1),
        .DEPTH (1 << AW)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // row of vertex cells; the minimum token walks from cell 0 upward
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        // take the fresh vertex count on the init beat of a run
        assign w_active[g]    = (32'(w_init ? w_n_eff : r_n) > g);
        assign w_is_src[g]    = (32'(r_src) == g);
        assign w_tok_valid[g] = w_tok_out[g].valid;
        if (g == 0) begin : g_head
            assign w_tok_in[g] = '{valid: r_tok_start, found: 1'b0, best: '0};
            assign w_idx_in[g] = '0;
        end else begin : g_link
            assign w_tok_in[g] = w_tok_out[g-1];
            assign w_idx_in[g] = w_idx_out[g-1];
        end
        ssp_cell #(
            .VW  (VW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_init      (w_init),
            .i_is_src    (w_is_src[g]),
            .i_active    (w_active[g]),
            .i_relax     (r_rx),
            .i_relax_col (r_rx_col),
            .i_visit     (w_visit),
            .i_visit_idx (w_idx_out[MAX_VERTICES-1]),
            .i_tok       (w_tok_in[g]),
            .i_tok_idx   (w_idx_in[g]),
            .o_tok       (w_tok_out[g]),
            .o_tok_idx   (w_idx_out[g]),
            .o_dist      (w_dist[g]),
            .o_reached   (w_reached[g])
        );
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.vertex_index = r_out_vidx;
    assign o_res.path_length  = r_out_path;
    assign o_res.reachable    = r_out_reach;
    assign o_res.last_result  = r_out_last;

    // requests are never taken while a result beat is pending
    `AST_NEVER(a_no_overlap, i_clk, i_rst_n, r_out_valid && i_req.ready)
    // at most one minimum token is in the chain
    `AST_IMP(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok_valid))
    // emission never runs past the vertex count
    `AST_IMP(a_emit_range, i_clk, i_rst_n, r_state == ST_EMIT, CW'(r_emit_idx) < r_n)

endmodule

/* test/tb_single_source_shortest_path_top.sv */
// Self-checking testbench for the dense-graph shortest path engine
`timescale 1ns / 100ps
module tb_single_source_shortest_path_top;
    import ssp_pkg::*;

    localparam int NV = 32;
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [4:0]  vertex_index;
        logic [20:0] path_length;
        logic        reachable;
        logic        last_result;
    } t_dist_res;

    // Graph model and expected distance beats
    class path_scoreboard;
        logic [16:0]   weights [NV][NV];
        logic [4:0]    source;
        logic [5:0]    count;
        t_dist_res     pending [$];
        int            mismatches;

        function void clear_graph();
            for (int i = 0; i < NV; i++)
                for (int j = 0; j < NV; j++)
                    weights[i][j] = '0;
        endfunction

        function void write_reg(logic idx, logic [5:0] data);
            if (idx == CFG_SOURCE) source = data[4:0];
            else count = data;
        endfunction

        function void compute_paths();
            int n;
            logic [20:0] dist_tab [NV];
            bit reached [NV];
            bit visited [NV];
            bit found;
            int cur;
            logic [21:0] best, cand;
            t_dist_res r;
            n = (count == 0) ? 1 : (count > NV ? NV : count);
            for (int v = 0; v < NV; v++) begin
                dist_tab[v] = '0;
                reached[v] = 0;
                visited[v] = 0;
            end
            if (source < n) reached[source] = 1;
            forever begin
                found = 0;
                cur = 0;
                best = '0;
                for (int v = 0; v < n; v++) begin
                    if (reached[v] && !visited[v] && (!found || dist_tab[v] < best)) begin
                        found = 1;
                        cur = v;
                        best = dist_tab[v];
                    end
                end
                if (!found) break;
                visited[cur] = 1;
                for (int j = 0; j < n; j++) begin
                    if (weights[cur][j][16]) begin
                        cand = best + weights[cur][j][15:0];
                        if (cand > 22'(DIST_MAX)) cand = 22'(DIST_MAX);
                        if (!reached[j] || cand < dist_tab[j]) begin
                            reached[j] = 1;
                            dist_tab[j] = cand[20:0];
                        end
                    end
                end
            end
            for (int v = 0; v < n; v++) begin
                r.vertex_index = v[4:0];
                r.path_length = reached[v] ? dist_tab[v] : '0;
                r.reachable = reached[v];
                r.last_result = (v == n - 1);
                pending.push_back(r);
            end
        endfunction

        function new();
            clear_graph();
            source = '0;
            count = 6'd32;
            mismatches = 0;
        endfunction

        // Note one accepted request beat
        function void note_request(logic [1:0] rt, logic [4:0] a, logic [4:0] b,
                                   logic [15:0] w);
            if (rt == REQ_LOAD) begin
                if (!weights[a][b][16]) weights[a][b] = {1'b1, w};
                if (!weights[b][a][16]) weights[b][a] = {1'b1, w};
            end else if (rt == REQ_RUN) begin
                compute_paths();
            end else if (rt == REQ_CLEAR) begin
                clear_graph();
            end
        endfunction

        // Compare one accepted result beat with the oldest expectation
        function void check_result(t_dist_res got);
            t_dist_res exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [5:0] i_cfg_data = '0;
    ssp_req_if req_if ();
    ssp_res_if res_if ();

    path_scoreboard sb;
    bit idle_on = 1;
    bit hold_off = 0;
    int cycles = 0;

    single_source_shortest_path_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req_if.sink), .o_res(res_if.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.vertex_a = '0;
        req_if.vertex_b = '0;
        req_if.edge_weight = '0;
        res_if.ready = 1'b0;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sink side: random stalls, a long hold-off when asked
    initial begin
        int gap;
        t_dist_res got;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                res_if.ready <= 1'b0;
                @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
                if (res_if.valid && res_if.ready) begin
                    got.vertex_index = res_if.vertex_index;
                    got.path_length = res_if.path_length;
                    got.reachable = res_if.reachable;
                    got.last_result = res_if.last_result;
                    sb.check_result(got);
                end
            end
        end
    end

    // Offer one request beat and wait for its acceptance
    task automatic send_request(logic [1:0] rt, logic [4:0] a, logic [4:0] b,
                                logic [15:0] w);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= rt;
        req_if.vertex_a <= a;
        req_if.vertex_b <= b;
        req_if.edge_weight <= w;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        sb.note_request(rt, a, b, w);
    endtask

    task automatic release_request();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every distance beat has arrived, then let the engine settle
    task automatic drain_results();
        release_request();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Random graph build then run, mostly dense small graphs
    task automatic random_phase(int items, int nv);
        int r;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                send_request(REQ_LOAD, $urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                             ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 50)));
            else if (r < 90) send_request(REQ_RUN, 5'($urandom), 5'($urandom), 16'($urandom));
            else if (r < 94) send_request(REQ_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom));
            else send_request(2'd3, 5'($urandom), 5'($urandom), 16'($urandom));
        end
        send_request(REQ_RUN, '0, '0, '0);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, self loop, duplicate, big weights, out-of-count edges
        write_reg(CFG_COUNT, 6'd4);
        write_reg(CFG_SOURCE, 5'd0);
        send_request(REQ_LOAD, 5'd0, 5'd1, 16'hFFFF);
        send_request(REQ_LOAD, 5'd1, 5'd0, 16'd7);
        send_request(REQ_LOAD, 5'd2, 5'd2, 16'd5);
        send_request(REQ_LOAD, 5'd1, 5'd2, 16'd0);
        send_request(REQ_LOAD, 5'd0, 5'd31, 16'd1);
        send_request(2'd3, 5'd31, 5'd31, 16'hFFFF);
        send_request(REQ_RUN, '0, '0, '0);
        drain_results();
        // Long chain of max weights nears but does not reach the saturated distance
        write_reg(CFG_COUNT, 6'd32);
        write_reg(CFG_SOURCE, 5'd31);
        for (int v = 0; v < 31; v++)
            send_request(REQ_LOAD, 5'(v), 5'(v + 1), 16'hFFFF);
        send_request(REQ_RUN, '0, '0, '0);
        drain_results();
        write_reg(CFG_COUNT, 6'd0);
        write_reg(CFG_SOURCE, 5'd0);
        send_request(REQ_RUN, '0, '0, '0);
        drain_results();
        write_reg(CFG_COUNT, 6'd63);
        write_reg(CFG_SOURCE, 5'd10);
        send_request(REQ_RUN, '0, '0, '0);
        drain_results();
        write_reg(CFG_COUNT, 6'd5);
        write_reg(CFG_SOURCE, 5'd20);
        send_request(REQ_RUN, '0, '0, '0);
        send_request(REQ_CLEAR, 5'd31, 5'd31, 16'hFFFF);
        send_request(REQ_RUN, '0, '0, '0);
        drain_results();

        // Pressure: hold the sink while requests wait behind stalled runs
        write_reg(CFG_COUNT, 6'd8);
        write_reg(CFG_SOURCE, 5'd3);
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(30, 8);
        join
        drain_results();

        // Random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) idle_on = 0;
            write_reg(CFG_COUNT, 6'($urandom_range(1, 33)));
            write_reg(CFG_SOURCE, 5'($urandom_range(0, 31)));
            random_phase(50, (ph % 2) ? 32 : 12);
            drain_results();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* single_source_shortest_path_top.f */
+incdir+src
src/ssp_pkg.sv
src/ssp_req_if.sv
src/ssp_res_if.sv
src/ssp_ram.sv
src/ssp_cell.sv
src/single_source_shortest_path_top.sv
test/tb_single_source_shortest_path_top.sv
